/* rtl/pcml_pkg.sv */
// ----------------------------------------------------------------------------
// pcml_pkg: shared constants and helpers of the passivity-controlled loop
// Widths of the serial units, register indexes and saturation functions.
// ----------------------------------------------------------------------------
package pcml_pkg;

  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MUL_CNT_W  = $clog2(MUL_W);
  localparam int DVD_W      = 64;
  localparam int DVS_W      = 32;
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PC_ENABLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_VEL_DIV = 3'd6;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 72'shFF_FFFF_FFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [71:0] v);
    logic signed [47:0] r;
    if (v > 72'sh7FFF_FFFF_FFFF) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < 72'shFF_FFFF_8000_0000_0000) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

/* rtl/pcml_mul.sv */
// ----------------------------------------------------------------------------
// pcml_mul: bit-serial signed multiplier
// Shift-and-add on magnitudes, one multiplier bit per cycle, sign at the end.
// ----------------------------------------------------------------------------
module pcml_mul
  import pcml_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic                     done,
  output logic signed [PROD_W-1:0] p
);

  logic                 busy_r, fin_r, done_r, neg_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_W-1:0]     ma_r, hi_r, lo_r;
  logic signed [PROD_W-1:0] p_r;
  logic [MUL_W:0]       sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ma_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r && !start && !busy_r;
      fin_r  <= busy_r && !start && (cnt_r == MUL_CNT_W'(MUL_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        hi_r   <= '0;
        ma_r   <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
        lo_r   <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
        neg_r  <= a[MUL_W-1] ^ b[MUL_W-1];
      end else if (busy_r) begin
        hi_r  <= sum[MUL_W:1];
        lo_r  <= {sum[0], lo_r[MUL_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
        end
      end else if (fin_r) begin
        p_r    <= neg_r ? -$signed({hi_r, lo_r}) : $signed({hi_r, lo_r});
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

/* rtl/pcml_div.sv */
// ----------------------------------------------------------------------------
// pcml_div: bit-serial unsigned restoring divider
// One quotient bit per cycle; the quotient stays valid until the next start.
// ----------------------------------------------------------------------------
module pcml_div
  import pcml_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic             done,
  output logic [DVD_W-1:0] q
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]     rem_r, d_r;
  logic [DVD_W-1:0]     q_r;
  logic [DVS_W:0]       rs;
  logic [DVS_W+1:0]     diff;

  assign rs   = {rem_r, q_r[DVD_W-1]};
  assign diff = {1'b0, rs} - {2'b00, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CNT_W'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        d_r    <= dvs;
        q_r    <= dvd;
      end else if (busy_r) begin
        rem_r <= diff[DVS_W+1] ? rs[DVS_W-1:0] : diff[DVS_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], ~diff[DVS_W+1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

/* rtl/passivity_controlled_master_loop.sv */
// ----------------------------------------------------------------------------
// passivity_controlled_master_loop: master servo tick with passivity control
// Integrates remote positions, runs the PID, observes channel energies and
// rescales velocities when a channel turns active, then emits the force.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload (low bits first)
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | raw_position, m2_velocity, m2_force, m2_pos_energy,
//          |           | slave_force, slave_velocity, slave_pos_energy
//  out_    | master    | tdata: force_cmd, master_velocity, pid_force,
//          |           | m1m2_energy, coupling_force, m1s_energy;
//          |           | tuser: result_valid
//  cfg_    | write     | index 0..6 selects the register, data in cfg_wdata
//
// A tick runs longer when a channel backtracks; its length is set by the
// shared bit-serial multiplier (8 to 14 products) and the bit-serial
// divider (one to three divisions). The first tick after reset latches
// only the zero position and emits a zeroed transfer with result_valid
// clear. Reset is synchronous and clears all loop state. A stalled output
// holds one finished transfer while the next input is taken; a second
// finished tick waits in its final state.
//
module passivity_controlled_master_loop
  import pcml_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // raw_position[31:0], m2_velocity[63:32], m2_force[95:64],
  // m2_pos_energy[143:96], slave_force[175:144], slave_velocity[207:176],
  // slave_pos_energy[255:208]
  input  logic [255:0]         in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // force_cmd[31:0], master_velocity[63:32], pid_force[95:64],
  // m1m2_energy[143:96], coupling_force[175:144], m1s_energy[223:176]
  output logic [223:0]         out_tdata,
  // result_valid[0]
  output logic [0:0]           out_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Sequencer states. Each compute state may start the multiplier or the
  // divider and then park in ST_WAIT, which returns to ret_r on completion.
  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001, ST_WAIT = 22'h000002, ST_POS  = 22'h000004,
    ST_PID0 = 22'h000008, ST_PID1 = 22'h000010, ST_PID2 = 22'h000020,
    ST_PID3 = 22'h000040, ST_E12  = 22'h000080, ST_E21  = 22'h000100,
    ST_CHK1 = 22'h000200, ST_RS1  = 22'h000400, ST_RS1D = 22'h000800,
    ST_E21B = 22'h001000, ST_E1S  = 22'h002000, ST_CPL  = 22'h004000,
    ST_CPL1 = 22'h008000, ST_ES   = 22'h010000, ST_CHK2 = 22'h020000,
    ST_RS2  = 22'h040000, ST_RS2D = 22'h080000, ST_ESB  = 22'h100000,
    ST_FIN  = 22'h200000
  } state_t;

  state_t state_r, ret_r;

  // Configuration registers.
  logic [23:0]        prop_r, deriv_r, integ_r, cgain_r;
  logic               pcen_r;
  logic [30:0]        lim_r;
  logic [9:0]         sdiv_r;

  // Latched inputs; the two velocities are overwritten by a rescale.
  logic signed [31:0] raw_r, vm2_r, fm2_r, fs_r, vs_r;
  logic signed [47:0] pm2_r, ps_r;

  // Loop state.
  logic               first_r;
  logic signed [31:0] zero_r, xm_r, ref_r, xs_r, iacc_r, prev_r;
  logic signed [47:0] e12_r, e21_r, e1s_r, esm_r;

  // Per-tick working registers.
  logic               item_first_r, bt_r, cbt_r, neg_r, zf_r;
  logic signed [31:0] x1_r, vm1_r, err_r, f1_r, fk_r;
  logic signed [PROD_W-1:0] t_r, pa_r, pb_r;

  // Output register.
  logic               out_valid_r;
  logic [223:0]       out_data_r;
  logic [0:0]         out_user_r;

  // Serial units.
  logic                     mul_start, mul_done, div_start, div_done;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, sh16;
  logic [DVD_W-1:0]         div_dvd, div_q;
  logic [DVS_W-1:0]         div_dvs;

  pcml_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(prod)
  );

  pcml_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dvd(div_dvd), .dvs(div_dvs),
    .done(div_done), .q(div_q)
  );

  logic               in_xfer;
  logic signed [31:0] in_raw, in_vs;
  logic               prod_pos;
  logic signed [32:0] err_diff;
  logic signed [31:0] err_now, pid_sum, fk_new, x1_now, qsat, lim_pos, lim_neg, fcmd;
  logic signed [71:0] q_slave;
  logic signed [47:0] esum1, esum2, rs_e;
  logic signed [31:0] rs_f;
  logic [47:0]        rs_emag;
  logic [31:0]        rs_fmag, vs_mag;
  logic               chk1, chk2;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign in_raw     = in_tdata[31:0];
  assign in_vs      = in_tdata[207:176];
  assign vs_mag     = in_vs[31] ? 32'(-in_vs) : 32'(in_vs);

  // Arithmetic shift keeps the floor rounding of the energy scaling.
  assign sh16       = prod >>> 16;
  assign prod_pos   = (prod > 68'sd0);
  assign err_diff   = 33'(err_r) - 33'(prev_r);
  assign err_now    = sat32(72'(ref_r) - 72'(x1_r));
  assign x1_now     = sat32(72'(raw_r) - 72'(zero_r));
  assign pid_sum    = sat32(72'(t_r) + 72'(sh16) + 72'(iacc_r));
  assign fk_new     = sat32(72'(prod >>> 24));

  // Slave velocity over the divisor, truncated toward zero.
  assign q_slave    = vs_r[31] ? -$signed({8'd0, div_q}) : $signed({8'd0, div_q});

  // Channel energy sums seen by the controllers.
  assign esum1      = sat48(72'(e21_r) + 72'(pm2_r));
  assign esum2      = sat48(72'(ps_r) + 72'(esm_r));
  assign chk1       = pcen_r && ((72'(e21_r) + 72'(pm2_r)) < 72'sd0);
  assign chk2       = (72'(ps_r) + 72'(esm_r)) < 72'sd0;

  // Velocity rescale operands: energy times 2^16 over the force.
  assign rs_e       = (state_r == ST_RS2) ? esum2 : esum1;
  assign rs_f       = (state_r == ST_RS2) ? fk_r : f1_r;
  assign rs_emag    = rs_e[47] ? 48'(-rs_e) : 48'(rs_e);
  assign rs_fmag    = rs_f[31] ? 32'(-rs_f) : 32'(rs_f);

  always_comb begin
    if (zf_r) begin
      qsat = 32'sd0;
    end else if (neg_r) begin
      qsat = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(div_q[31:0]);
    end else begin
      qsat = (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]);
    end
  end

  // Symmetric clamp of the coupling force.
  assign lim_pos = $signed({1'b0, lim_r});
  assign lim_neg = -lim_pos;
  always_comb begin
    if (fk_r > lim_pos) begin
      fcmd = lim_pos;
    end else if (fk_r < lim_neg) begin
      fcmd = lim_neg;
    end else begin
      fcmd = fk_r;
    end
  end

  // Operand selection for the serial units.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = {16'd0, rs_emag} << 16;
    div_dvs   = rs_fmag;
    unique case (state_r)
      ST_IDLE: begin
        div_start = in_xfer && first_r == 1'b0;
        div_dvd   = DVD_W'(vs_mag);
        div_dvs   = (sdiv_r == 10'd0) ? 32'd1 : 32'(sdiv_r);
      end
      ST_PID0: begin
        mul_start = 1'b1;
        mul_a     = $signed({10'd0, integ_r});
        mul_b     = MUL_W'(err_now);
      end
      ST_PID1: begin
        mul_start = 1'b1;
        mul_a     = $signed({10'd0, prop_r});
        mul_b     = MUL_W'(err_r);
      end
      ST_PID2: begin
        mul_start = 1'b1;
        mul_a     = $signed({10'd0, deriv_r});
        mul_b     = MUL_W'(err_diff);
      end
      ST_PID3: begin
        mul_start = 1'b1;
        mul_a     = bt_r ? MUL_W'(pid_sum) : MUL_W'(fm2_r);
        mul_b     = bt_r ? MUL_W'(vm2_r) : MUL_W'(vm1_r);
      end
      ST_E12: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(f1_r);
        mul_b     = MUL_W'(vm2_r);
      end
      ST_CHK1: begin
        mul_start = !chk1;
        mul_a     = MUL_W'(vm1_r);
        mul_b     = MUL_W'(fs_r);
      end
      ST_E21B: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(vm1_r);
        mul_b     = MUL_W'(fs_r);
      end
      ST_CPL: begin
        // Multiply by the negated gap so the product already carries the sign.
        mul_start = 1'b1;
        mul_a     = $signed({10'd0, cgain_r});
        mul_b     = MUL_W'(xs_r) - MUL_W'(x1_r);
      end
      ST_CPL1: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(fk_new);
        mul_b     = MUL_W'(vs_r);
      end
      ST_RS1, ST_RS2: begin
        div_start = (rs_f != 32'sd0);
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r  <= 24'd13107;
      deriv_r <= 24'd66;
      integ_r <= 24'd66;
      cgain_r <= 24'd1678;
      pcen_r  <= 1'b1;
      lim_r   <= 31'd327680;
      sdiv_r  <= 10'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     prop_r  <= cfg_wdata[23:0];
        REG_DERIV_GAIN:    deriv_r <= cfg_wdata[23:0];
        REG_INTEG_GAIN:    integ_r <= cfg_wdata[23:0];
        REG_COUPLING_GAIN: cgain_r <= cfg_wdata[23:0];
        REG_PC_ENABLE:     pcen_r  <= cfg_wdata[0];
        REG_FORCE_LIMIT:   lim_r   <= cfg_wdata[30:0];
        REG_SLAVE_VEL_DIV: sdiv_r  <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and loop state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      first_r     <= 1'b1;
      zero_r      <= '0;
      xm_r        <= '0;
      ref_r       <= '0;
      xs_r        <= '0;
      iacc_r      <= '0;
      prev_r      <= '0;
      e12_r       <= '0;
      e21_r       <= '0;
      e1s_r       <= '0;
      esm_r       <= '0;
      bt_r        <= 1'b0;
      cbt_r       <= 1'b0;
      zf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The final state reloads the output register itself when it drains.
      if (out_valid_r && out_tready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            raw_r        <= in_raw;
            vm2_r        <= in_tdata[63:32];
            fm2_r        <= in_tdata[95:64];
            pm2_r        <= in_tdata[143:96];
            fs_r         <= in_tdata[175:144];
            vs_r         <= in_vs;
            ps_r         <= in_tdata[255:208];
            item_first_r <= first_r;
            if (first_r) begin
              zero_r  <= in_raw;
              first_r <= 1'b0;
              state_r <= ST_FIN;
            end else begin
              ret_r   <= ST_POS;
              state_r <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (mul_done || div_done) begin
            state_r <= ret_r;
          end
        end
        ST_POS: begin
          xs_r    <= sat32(72'(xs_r) + q_slave);
          ref_r   <= sat32(72'(ref_r) + 72'(vm2_r));
          x1_r    <= x1_now;
          vm1_r   <= sat32(72'(x1_now) - 72'(xm_r));
          xm_r    <= x1_now;
          bt_r    <= 1'b0;
          cbt_r   <= 1'b0;
          state_r <= ST_PID0;
        end
        ST_PID0: begin
          err_r   <= err_now;
          ret_r   <= ST_PID1;
          state_r <= ST_WAIT;
        end
        ST_PID1: begin
          iacc_r  <= sat32(72'(iacc_r) + 72'(sh16));
          ret_r   <= ST_PID2;
          state_r <= ST_WAIT;
        end
        ST_PID2: begin
          t_r     <= sh16;
          ret_r   <= ST_PID3;
          state_r <= ST_WAIT;
        end
        ST_PID3: begin
          f1_r    <= pid_sum;
          prev_r  <= err_r;
          ret_r   <= bt_r ? ST_E21B : ST_E12;
          state_r <= ST_WAIT;
        end
        ST_E12: begin
          if (prod_pos) begin
            e12_r <= sat48(72'(e12_r) + 72'(sh16));
          end
          ret_r   <= ST_E21;
          state_r <= ST_WAIT;
        end
        ST_E21: begin
          if (prod_pos) begin
            e21_r <= sat48(72'(e21_r) - 72'(sh16));
          end
          pa_r    <= sh16;
          state_r <= ST_CHK1;
        end
        ST_CHK1: begin
          // Master-2 channel went active: undo this tick's step first.
          if (chk1) begin
            e21_r   <= sat48(72'(e21_r) + 72'(pa_r));
            ref_r   <= sat32(72'(ref_r) - 72'(vm2_r));
            state_r <= ST_RS1;
          end else begin
            ret_r   <= ST_E1S;
            state_r <= ST_WAIT;
          end
        end
        ST_RS1: begin
          zf_r    <= (rs_f == 32'sd0);
          neg_r   <= rs_e[47] ^ rs_f[31];
          ret_r   <= ST_RS1D;
          state_r <= (rs_f == 32'sd0) ? ST_RS1D : ST_WAIT;
        end
        ST_RS1D: begin
          vm2_r   <= qsat;
          ref_r   <= sat32(72'(ref_r) + 72'(qsat));
          bt_r    <= 1'b1;
          state_r <= ST_PID0;
        end
        ST_E21B: begin
          e21_r   <= sat48(72'(e21_r) - 72'(sh16));
          ret_r   <= ST_E1S;
          state_r <= ST_WAIT;
        end
        ST_E1S: begin
          if (prod_pos) begin
            e1s_r <= sat48(72'(e1s_r) + 72'(sh16));
          end
          state_r <= ST_CPL;
        end
        ST_CPL: begin
          ret_r   <= ST_CPL1;
          state_r <= ST_WAIT;
        end
        ST_CPL1: begin
          fk_r    <= fk_new;
          ret_r   <= cbt_r ? ST_ESB : ST_ES;
          state_r <= ST_WAIT;
        end
        ST_ES: begin
          if (prod_pos) begin
            esm_r <= sat48(72'(esm_r) - 72'(sh16));
          end
          pb_r    <= sh16;
          state_r <= ST_CHK2;
        end
        ST_CHK2: begin
          // Slave channel went active: undo the full slave velocity step.
          if (chk2) begin
            esm_r   <= sat48(72'(esm_r) + 72'(pb_r));
            xs_r    <= sat32(72'(xs_r) - 72'(vs_r));
            state_r <= ST_RS2;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_RS2: begin
          zf_r    <= (rs_f == 32'sd0);
          neg_r   <= rs_e[47] ^ rs_f[31];
          ret_r   <= ST_RS2D;
          state_r <= (rs_f == 32'sd0) ? ST_RS2D : ST_WAIT;
        end
        ST_RS2D: begin
          vs_r    <= qsat;
          xs_r    <= sat32(72'(xs_r) + 72'(qsat));
          cbt_r   <= 1'b1;
          state_r <= ST_CPL;
        end
        ST_ESB: begin
          esm_r   <= sat48(72'(esm_r) - 72'(sh16));
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // Load the output register once it is free or being drained.
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            if (item_first_r) begin
              out_data_r <= '0;
              out_user_r <= 1'b0;
            end else begin
              out_data_r <= {e1s_r, fk_r, e12_r, f1_r, vm1_r, fcmd};
              out_user_r <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
